// File: design/dbr_pkg.sv
// ============================================================================
// dbr_pkg
// shared sizes, opcodes, register indexes and control structs of the
// dense bias relu layer
// ============================================================================
package dbr_pkg;

    // layer geometry
    localparam int IN_FEATURES  = 32;
    localparam int OUT_FEATURES = 16;
    localparam int ACC_WIDTH    = 40;

    localparam int WEIGHT_DEPTH = IN_FEATURES * OUT_FEATURES;
    localparam int WA_W = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int OC_W = (OUT_FEATURES > 1) ? $clog2(OUT_FEATURES) : 1;
    localparam int FC_W = (IN_FEATURES > 1) ? $clog2(IN_FEATURES) : 1;

    // port field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 9;
    localparam int WGT_W      = 8;
    localparam int BIAS_W     = 32;
    localparam int FEAT_W     = 8;
    localparam int PROD_W     = WGT_W + FEAT_W;
    localparam int RES_W      = 8;
    localparam int CHAN_W     = 4;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // request opcodes
    localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
    localparam logic [OP_W-1:0] OP_FEATURE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELU     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATE = 3'd4;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift_amount;
        logic               relu_enable;
        logic               bias_enable;
        logic               round_mode;
        logic               saturate_enable;
    } dbr_cfg_t;

    // store writes from the request channel
    typedef struct packed {
        logic                     mem_we;
        logic [WA_W-1:0]          mem_addr;
        logic signed [WGT_W-1:0]  mem_data;
        logic                     bias_we;
        logic [OC_W-1:0]          bias_addr;
        logic signed [BIAS_W-1:0] bias_data;
    } dbr_store_wr_t;

    // one multiply-accumulate issue
    typedef struct packed {
        logic            rd_en;
        logic [WA_W-1:0] rd_addr;
        logic [OC_W-1:0] chan;
        logic            seed;
    } dbr_mac_cmd_t;

    // one result to narrow and emit
    typedef struct packed {
        logic            load;
        logic [OC_W-1:0] chan;
        logic            last;
    } dbr_emit_t;

    function automatic logic signed [ACC_WIDTH-1:0] bias_to_acc(
        input logic signed [BIAS_W-1:0] b
    );
        logic signed [63:0] t;
        t = 64'(b);
        return t[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] prod_to_acc(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [63:0] t;
        t = 64'(p);
        return t[ACC_WIDTH-1:0];
    endfunction

endpackage

// File: design/dense_bias_relu_layer.sv
// ============================================================================
// dense_bias_relu_layer
// quantized fully connected layer with int8 weights, 32-bit bias,
// shift/round/saturate narrowing and optional relu
// ============================================================================
// Requests on the s_ channel either write a weight (op 0, address
// input*OUT_FEATURES+output), write a bias (op 1), or deliver one feature of
// the current row (op 2); out-of-range store writes and op 3 are dropped.
// For each feature a single shared 8x8 multiplier and ACC_WIDTH-bit adder
// updates one output accumulator per cycle, reading its weight from the
// weight memory, and s_ready stays low meanwhile. After the last feature of
// a row the block passes through a drain state for the accumulate pipe and
// then emits the OUT_FEATURES results in channel order, one per cycle at
// best, paced by m_ready; out_last marks the last channel. Stores need no
// clearing pass after reset; entries must be written before a row reads
// them.
// ============================================================================
module dense_bias_relu_layer
    import dbr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // requests
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [IDX_W-1:0]         s_store_index,
    input  logic signed [WGT_W-1:0]  s_weight_value,
    input  logic signed [BIAS_W-1:0] s_bias_value,
    input  logic signed [FEAT_W-1:0] s_feature_value,

    // results
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [RES_W-1:0]  m_out_value,
    output logic [CHAN_W-1:0]        m_out_channel,
    output logic                     m_out_last,

    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    dbr_cfg_t                    cfg;
    dbr_store_wr_t               store_wr;
    dbr_mac_cmd_t                mac_cmd;
    dbr_emit_t                   emit;
    logic signed [FEAT_W-1:0]    feature;
    logic signed [ACC_WIDTH-1:0] acc_val;
    logic                        slot_free;

    // shift, rounding, saturation, relu and bias select
    dbr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // decode requests, step channels per feature, step readout per row
    dbr_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_store_index   (s_store_index),
        .s_weight_value  (s_weight_value),
        .s_bias_value    (s_bias_value),
        .s_feature_value (s_feature_value),
        .slot_free       (slot_free),
        .store_wr        (store_wr),
        .mac_cmd         (mac_cmd),
        .feature         (feature),
        .emit            (emit)
    );

    // stores and the shared multiply-accumulate
    dbr_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .store_wr    (store_wr),
        .mac_cmd     (mac_cmd),
        .feature     (feature),
        .bias_enable (cfg.bias_enable),
        .emit_chan   (emit.chan),
        .acc_out     (acc_val)
    );

    // narrowing and the result register
    dbr_finish u_finish (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc_in        (acc_val),
        .cfg           (cfg),
        .emit          (emit),
        .slot_free     (slot_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_out_channel (m_out_channel),
        .m_out_last    (m_out_last)
    );

endmodule

// File: design/dbr_cfg.sv
// ============================================================================
// dbr_cfg
// configuration register file, written through its own valid/ready channel
// ============================================================================
module dbr_cfg
    import dbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dbr_cfg_t              cfg
);

    dbr_cfg_t cfg_reg;
    dbr_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SHIFT:    cfg_next.shift_amount    = cfg_data[SHIFT_W-1:0];
                REG_RELU:     cfg_next.relu_enable     = cfg_data[0];
                REG_BIAS_EN:  cfg_next.bias_enable     = cfg_data[0];
                REG_ROUND:    cfg_next.round_mode      = cfg_data[0];
                REG_SATURATE: cfg_next.saturate_enable = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shift_amount    <= '0;
            cfg_reg.relu_enable     <= 1'b1;
            cfg_reg.bias_enable     <= 1'b1;
            cfg_reg.round_mode      <= 1'b0;
            cfg_reg.saturate_enable <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/dbr_mac.sv
// ============================================================================
// dbr_mac
// weight memory, bias and accumulator registers and the shared
// multiply-accumulate unit
// ============================================================================
module dbr_mac
    import dbr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dbr_store_wr_t               store_wr,
    input  dbr_mac_cmd_t                mac_cmd,
    input  logic signed [FEAT_W-1:0]    feature,
    input  logic                        bias_enable,
    input  logic [OC_W-1:0]             emit_chan,
    output logic signed [ACC_WIDTH-1:0] acc_out
);

    logic signed [WGT_W-1:0]     weight_mem [WEIGHT_DEPTH];
    logic signed [BIAS_W-1:0]    bias_reg   [OUT_FEATURES];
    logic signed [ACC_WIDTH-1:0] acc_reg    [OUT_FEATURES];

    logic signed [WGT_W-1:0] wrd_reg;
    logic                    b_valid_reg;
    logic [OC_W-1:0]         b_chan_reg;
    logic                    b_seed_reg;

    logic [OC_W-1:0]             acc_idx;
    logic signed [ACC_WIDTH-1:0] acc_rd;
    logic signed [ACC_WIDTH-1:0] base;
    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_WIDTH-1:0] sum;

    // one accumulator read port, shared between update and readout
    assign acc_idx = b_valid_reg ? b_chan_reg : emit_chan;
    assign acc_rd  = acc_reg[acc_idx];
    assign acc_out = acc_rd;

    always_comb begin
        if (b_seed_reg) begin
            base = bias_enable ? bias_to_acc(bias_reg[b_chan_reg]) : '0;
        end else begin
            base = acc_rd;
        end
        prod = feature * wrd_reg;
        sum  = base + prod_to_acc(prod);
    end

    always_ff @(posedge aclk) begin
        if (store_wr.mem_we) begin
            weight_mem[store_wr.mem_addr] <= store_wr.mem_data;
        end
        if (mac_cmd.rd_en) begin
            wrd_reg <= weight_mem[mac_cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (store_wr.bias_we) begin
            bias_reg[store_wr.bias_addr] <= store_wr.bias_data;
        end
        if (b_valid_reg) begin
            acc_reg[b_chan_reg] <= sum;
        end
        b_chan_reg <= mac_cmd.chan;
        b_seed_reg <= mac_cmd.seed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= mac_cmd.rd_en;
        end
    end

endmodule

// File: design/dbr_finish.sv
// ============================================================================
// dbr_finish
// shift, rounding, narrowing and relu of one accumulator into the
// result output register
// ============================================================================
module dbr_finish
    import dbr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [ACC_WIDTH-1:0] acc_in,
    input  dbr_cfg_t                    cfg,
    input  dbr_emit_t                   emit,
    output logic                        slot_free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RES_W-1:0]     m_out_value,
    output logic [CHAN_W-1:0]           m_out_channel,
    output logic                        m_out_last
);

    localparam int QW = ACC_WIDTH + 1;
    localparam logic signed [QW-1:0] QMIN = QW'(-128);
    localparam logic signed [QW-1:0] QMAX = QW'(127);

    logic signed [ACC_WIDTH:0] ext;
    logic signed [ACC_WIDTH:0] shifted;
    logic signed [QW-1:0]      q;
    logic signed [QW-1:0]      qr;
    logic                      rbit;
    logic signed [RES_W-1:0]   r;
    logic signed [RES_W-1:0]   res;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic signed [RES_W-1:0] value_reg;
    logic [CHAN_W-1:0]       chan_reg;
    logic                    last_reg;

    // bit 0 after the shift is the bit just below the cut
    always_comb begin
        ext     = {acc_in, 1'b0};
        shifted = ext >>> cfg.shift_amount;
        q       = {shifted[ACC_WIDTH], shifted[ACC_WIDTH:1]};
        rbit    = cfg.round_mode & shifted[0];
        qr      = q + {{ACC_WIDTH{1'b0}}, rbit};
        if (!cfg.saturate_enable) begin
            r = qr[RES_W-1:0];
        end else if (qr < QMIN) begin
            r = QMIN[RES_W-1:0];
        end else if (qr > QMAX) begin
            r = QMAX[RES_W-1:0];
        end else begin
            r = qr[RES_W-1:0];
        end
        res = (cfg.relu_enable && r[RES_W-1]) ? '0 : r;
    end

    assign slot_free     = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_out_value   = value_reg;
    assign m_out_channel = chan_reg;
    assign m_out_last    = last_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.load) begin
            value_reg <= res;
            chan_reg  <= CHAN_W'(emit.chan);
            last_reg  <= emit.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/dbr_seq.sv
// ============================================================================
// dbr_seq
// request decode and sequencer: issues one multiply-accumulate per cycle
// per feature and steps the result readout at the end of a row
// ============================================================================
module dbr_seq
    import dbr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [IDX_W-1:0]         s_store_index,
    input  logic signed [WGT_W-1:0]  s_weight_value,
    input  logic signed [BIAS_W-1:0] s_bias_value,
    input  logic signed [FEAT_W-1:0] s_feature_value,
    input  logic                     slot_free,
    output dbr_store_wr_t            store_wr,
    output dbr_mac_cmd_t             mac_cmd,
    output logic signed [FEAT_W-1:0] feature,
    output dbr_emit_t                emit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } state_t;

    localparam logic [OC_W-1:0] OC_LAST = OC_W'(OUT_FEATURES - 1);
    localparam logic [FC_W-1:0] FC_LAST = FC_W'(IN_FEATURES - 1);

    state_t                  state_reg, state_next;
    logic [OC_W-1:0]         o_reg, o_next;
    logic [OC_W-1:0]         e_reg, e_next;
    logic [FC_W-1:0]         fc_reg, fc_next;
    logic [WA_W-1:0]         addr_reg, addr_next;
    logic signed [FEAT_W-1:0] feature_reg, feature_next;

    logic accept;
    logic end_feature;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign feature = feature_reg;

    always_comb begin
        store_wr.mem_we    = accept && (s_op == OP_WEIGHT)
                             && (32'(s_store_index) < WEIGHT_DEPTH);
        store_wr.mem_addr  = WA_W'(s_store_index);
        store_wr.mem_data  = s_weight_value;
        store_wr.bias_we   = accept && (s_op == OP_BIAS)
                             && (32'(s_store_index) < OUT_FEATURES);
        store_wr.bias_addr = OC_W'(s_store_index);
        store_wr.bias_data = s_bias_value;
    end

    always_comb begin
        state_next   = state_reg;
        o_next       = o_reg;
        e_next       = e_reg;
        fc_next      = fc_reg;
        addr_next    = addr_reg;
        feature_next = feature_reg;
        end_feature  = 1'b0;

        mac_cmd.rd_en   = 1'b0;
        mac_cmd.rd_addr = addr_reg;
        mac_cmd.chan    = (state_reg == S_MAC) ? o_reg : '0;
        mac_cmd.seed    = (fc_reg == '0);

        emit.load = 1'b0;
        emit.chan = e_reg;
        emit.last = (e_reg == OC_LAST);

        case (state_reg)
            S_IDLE: begin
                if (accept && (s_op == OP_FEATURE)) begin
                    mac_cmd.rd_en = 1'b1;
                    feature_next  = s_feature_value;
                    addr_next     = addr_reg + WA_W'(1);
                    if (OUT_FEATURES == 1) begin
                        end_feature = 1'b1;
                    end else begin
                        state_next = S_MAC;
                        o_next     = OC_W'(1);
                    end
                end
            end
            S_MAC: begin
                mac_cmd.rd_en = 1'b1;
                addr_next     = addr_reg + WA_W'(1);
                o_next        = o_reg + OC_W'(1);
                if (o_reg == OC_LAST) begin
                    end_feature = 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_EMIT;
                e_next     = '0;
            end
            S_EMIT: begin
                if (slot_free) begin
                    emit.load = 1'b1;
                    if (e_reg == OC_LAST) begin
                        state_next = S_IDLE;
                    end else begin
                        e_next = e_reg + OC_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // row bookkeeping once the last channel of a feature is issued
        if (end_feature) begin
            if (fc_reg == FC_LAST) begin
                fc_next    = '0;
                addr_next  = '0;
                state_next = S_DRAIN;
            end else begin
                fc_next    = fc_reg + FC_W'(1);
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            o_reg     <= '0;
            e_reg     <= '0;
            fc_reg    <= '0;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            o_reg     <= o_next;
            e_reg     <= e_next;
            fc_reg    <= fc_next;
            addr_reg  <= addr_next;
        end
        feature_reg <= feature_next;
    end

    a_fc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= FC_LAST)
        else $error("feature count beyond row length");

    a_addr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_cmd.rd_en |->
            32'(addr_reg) == 32'(fc_reg) * OUT_FEATURES + 32'(mac_cmd.chan))
        else $error("weight read address out of step with feature and channel");

    a_emit_row_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (fc_reg == '0) && (addr_reg == '0))
        else $error("readout with row counters not rewound");

endmodule
